// ----- design/mcr_pkg.sv -----
// package for the midpoint circle rasterizer
// widths, input op codes and the step job handed from front to back
// no dependencies
package mcr_pkg;

   localparam int COORD_WIDTH_DEFAULT = 12;
   localparam int CENTRE_WIDTH = 10;
   localparam int RADIUS_WIDTH = 9;
   localparam int OFF_WIDTH = 10;
   localparam int DEC_WIDTH = 14;
   localparam int SUM_WIDTH = 12;
   localparam int QUEUE_DEPTH = 2;
   localparam int PIXELS_PER_STEP = 8;
   localparam int PIX_IDX_WIDTH = $clog2(PIXELS_PER_STEP);

   localparam logic OP_START = 1'b0;
   localparam logic OP_STEP = 1'b1;

   localparam logic [DEC_WIDTH-1:0] DEC_INIT = DEC_WIDTH'(3);
   localparam logic [DEC_WIDTH-1:0] DEC_ADD_DIAG = DEC_WIDTH'(10);
   localparam logic [DEC_WIDTH-1:0] DEC_ADD_STRAIGHT = DEC_WIDTH'(6);

   typedef struct packed {
      logic [CENTRE_WIDTH-1:0] cx;
      logic [CENTRE_WIDTH-1:0] cy;
      logic [OFF_WIDTH-1:0] x;
      logic [OFF_WIDTH-1:0] y;
      logic done;
   } step_job_type;

endpackage

// ----- design/mcr_if.sv -----
// channel interfaces for the midpoint circle rasterizer
// depends on mcr_pkg
interface mcr_req_if;
   import mcr_pkg::*;

   logic valid;
   logic ready;
   logic op;
   logic [CENTRE_WIDTH-1:0] centre_x;
   logic [CENTRE_WIDTH-1:0] centre_y;
   logic [RADIUS_WIDTH-1:0] radius;

   modport source (output valid, op, centre_x, centre_y, radius, input ready);
   modport sink (input valid, op, centre_x, centre_y, radius, output ready);
endinterface

interface mcr_rsp_if #(
   parameter int COORD_WIDTH = mcr_pkg::COORD_WIDTH_DEFAULT
);
   logic valid;
   logic ready;
   logic signed [COORD_WIDTH-1:0] pixel_x;
   logic signed [COORD_WIDTH-1:0] pixel_y;
   logic last_of_step;
   logic circle_done;

   modport source (output valid, pixel_x, pixel_y, last_of_step, circle_done,
                   input ready);
   modport sink (input valid, pixel_x, pixel_y, last_of_step, circle_done,
                 output ready);
endinterface

// ----- design/midpoint_circle_rasterizer_unit.sv -----
// midpoint circle rasterizer, top level: front, job queue, back
// a step beat reaches the output through the queue, the back's job register and its output register
// the back's output register gives one pixel beat a cycle while the receiver is ready
// start beats give no pixels; the two-entry queue lets steps enter back to back until it is full
// reset is synchronous, active high, and clears the circle state, queue and output valid
// depends on mcr_pkg, mcr_if, mcr_front, mcr_queue, mcr_back
module midpoint_circle_rasterizer_unit #(
   parameter int COORD_WIDTH = mcr_pkg::COORD_WIDTH_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   mcr_req_if.sink req_chan,
   mcr_rsp_if.source rsp_chan
);
   import mcr_pkg::*;

   logic push_valid, push_ready;
   logic pop_valid, pop_ready;
   step_job_type push_data, pop_data;

   mcr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .job_valid (push_valid),
      .job_ready (push_ready),
      .job_data  (push_data)
   );

   mcr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   mcr_back #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (pop_valid),
      .job_ready (pop_ready),
      .job_data  (pop_data),
      .rsp_chan  (rsp_chan)
   );

endmodule

// ----- design/mcr_queue.sv -----
// short job queue between the front and the back
// depends on mcr_pkg
module mcr_queue (
   input  logic clock,
   input  logic reset,
   input  logic push_valid,
   output logic push_ready,
   input  mcr_pkg::step_job_type push_data,
   output logic pop_valid,
   input  logic pop_ready,
   output mcr_pkg::step_job_type pop_data
);
   import mcr_pkg::*;

   localparam int PTR_WIDTH = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

   step_job_type mem_ff [QUEUE_DEPTH];
   logic [PTR_WIDTH-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_WIDTH-1:0] count_ff, count_in;
   logic do_push, do_pop;

   assign push_ready = (count_ff != CNT_WIDTH'(QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_data = mem_ff[rd_ptr_ff];
   assign do_push = push_valid && push_ready;
   assign do_pop = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- design/mcr_front.sv -----
// front end: accepts request beats, holds the circle state and
// turns each live step into a job for the queue; depends on mcr_pkg, mcr_if
module mcr_front (
   input  logic clock,
   input  logic reset,
   mcr_req_if.sink req_chan,
   output logic job_valid,
   input  logic job_ready,
   output mcr_pkg::step_job_type job_data
);
   import mcr_pkg::*;

   logic [OFF_WIDTH-1:0] offset_x_ff, offset_x_in;
   logic [OFF_WIDTH-1:0] offset_y_ff, offset_y_in;
   logic [DEC_WIDTH-1:0] decision_ff, decision_in;
   logic [CENTRE_WIDTH-1:0] centre_x_ff, centre_x_in;
   logic [CENTRE_WIDTH-1:0] centre_y_ff, centre_y_in;
   logic active_ff, active_in;

   logic accept;
   logic dec_pos;
   logic [DEC_WIDTH-1:0] x4, y4, dec_next;
   logic [SUM_WIDTH-1:0] x_next, y_next;
   logic done;

   assign req_chan.ready = job_ready;
   assign accept = req_chan.valid && req_chan.ready;

   assign dec_pos = !decision_ff[DEC_WIDTH-1] && (decision_ff != '0);
   assign x4 = {DEC_WIDTH'(offset_x_ff)} << 2;
   assign y4 = {DEC_WIDTH'(offset_y_ff)} << 2;
   assign dec_next = dec_pos ? (decision_ff + x4 - y4 + DEC_ADD_DIAG)
                             : (decision_ff + x4 + DEC_ADD_STRAIGHT);
   assign x_next = SUM_WIDTH'(offset_x_ff) + SUM_WIDTH'(1);
   assign y_next = SUM_WIDTH'(offset_y_ff) - SUM_WIDTH'(dec_pos);
   assign done = $signed(x_next) > $signed(y_next);

   assign job_valid = accept && (req_chan.op == OP_STEP) && active_ff;
   assign job_data.cx = centre_x_ff;
   assign job_data.cy = centre_y_ff;
   assign job_data.x = offset_x_ff;
   assign job_data.y = offset_y_ff;
   assign job_data.done = done;

   always_comb begin
      offset_x_in = offset_x_ff;
      offset_y_in = offset_y_ff;
      decision_in = decision_ff;
      centre_x_in = centre_x_ff;
      centre_y_in = centre_y_ff;
      active_in = active_ff;
      if (accept) begin
         if (req_chan.op == OP_START) begin
            centre_x_in = req_chan.centre_x;
            centre_y_in = req_chan.centre_y;
            offset_x_in = '0;
            offset_y_in = OFF_WIDTH'(req_chan.radius);
            decision_in = DEC_INIT - (DEC_WIDTH'(req_chan.radius) << 1);
            active_in = 1'b1;
         end else if (active_ff) begin
            offset_x_in = x_next[OFF_WIDTH-1:0];
            offset_y_in = y_next[OFF_WIDTH-1:0];
            decision_in = dec_next;
            if (done) begin
               active_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_x_ff <= '0;
         offset_y_ff <= '0;
         decision_ff <= '0;
         centre_x_ff <= '0;
         centre_y_ff <= '0;
         active_ff <= 1'b0;
      end else begin
         offset_x_ff <= offset_x_in;
         offset_y_ff <= offset_y_in;
         decision_ff <= decision_in;
         centre_x_ff <= centre_x_in;
         centre_y_ff <= centre_y_in;
         active_ff <= active_in;
      end
   end

endmodule

// ----- design/mcr_back.sv -----
// back end: takes one job from the queue and sends its eight
// symmetric pixels through an output register; depends on mcr_pkg, mcr_if
module mcr_back #(
   parameter int COORD_WIDTH = mcr_pkg::COORD_WIDTH_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  logic job_valid,
   output logic job_ready,
   input  mcr_pkg::step_job_type job_data,
   mcr_rsp_if.source rsp_chan
);
   import mcr_pkg::*;

   localparam int WORK_WIDTH = (COORD_WIDTH > SUM_WIDTH) ? COORD_WIDTH : SUM_WIDTH;
   localparam logic [PIX_IDX_WIDTH-1:0] LAST_IDX = PIX_IDX_WIDTH'(PIXELS_PER_STEP - 1);

   step_job_type job_ff, job_in;
   logic busy_ff, busy_in;
   logic [PIX_IDX_WIDTH-1:0] idx_ff, idx_in;
   logic out_valid_ff, out_valid_in;
   logic [COORD_WIDTH-1:0] pixel_x_ff, pixel_x_in;
   logic [COORD_WIDTH-1:0] pixel_y_ff, pixel_y_in;
   logic last_ff, last_in;
   logic done_ff, done_in;

   logic load, take;
   logic swap;
   logic [WORK_WIDTH-1:0] off_a, off_b, sum_x, sum_y;

   assign load = busy_ff && (!out_valid_ff || rsp_chan.ready);
   assign job_ready = !busy_ff || (load && (idx_ff == LAST_IDX));
   assign take = job_valid && job_ready;

   // octant pairs in the upper half swap the roles of x and y
   assign swap = idx_ff[2];
   assign off_a = swap ? WORK_WIDTH'(job_ff.y) : WORK_WIDTH'(job_ff.x);
   assign off_b = swap ? WORK_WIDTH'(job_ff.x) : WORK_WIDTH'(job_ff.y);
   assign sum_x = idx_ff[0] ? WORK_WIDTH'(job_ff.cx) - off_a : WORK_WIDTH'(job_ff.cx) + off_a;
   assign sum_y = idx_ff[1] ? WORK_WIDTH'(job_ff.cy) - off_b : WORK_WIDTH'(job_ff.cy) + off_b;

   always_comb begin
      job_in = job_ff;
      busy_in = busy_ff;
      idx_in = idx_ff;
      out_valid_in = out_valid_ff && !rsp_chan.ready;
      pixel_x_in = pixel_x_ff;
      pixel_y_in = pixel_y_ff;
      last_in = last_ff;
      done_in = done_ff;
      if (load) begin
         out_valid_in = 1'b1;
         pixel_x_in = sum_x[COORD_WIDTH-1:0];
         pixel_y_in = sum_y[COORD_WIDTH-1:0];
         last_in = (idx_ff == LAST_IDX);
         done_in = job_ff.done;
         idx_in = idx_ff + 1'b1;
         if (idx_ff == LAST_IDX) begin
            busy_in = 1'b0;
         end
      end
      if (take) begin
         job_in = job_data;
         busy_in = 1'b1;
         idx_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         idx_ff <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
      pixel_x_ff <= pixel_x_in;
      pixel_y_ff <= pixel_y_in;
      last_ff <= last_in;
      done_ff <= done_in;
   end

   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.pixel_x = pixel_x_ff;
   assign rsp_chan.pixel_y = pixel_y_ff;
   assign rsp_chan.last_of_step = last_ff;
   assign rsp_chan.circle_done = done_ff;

endmodule
